// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted
`define U8_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define U8_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/u8u16_pkg.sv =====
`timescale 1ns / 1ps

package u8u16_pkg;

  // Per-string completion status
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_LEAD  = 3'd1,
    ST_BAD_CONT  = 3'd2,
    ST_TRUNC     = 3'd3,
    ST_RANGE     = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  localparam logic [20:0] BOM_CP      = 21'h00FEFF;
  localparam logic [20:0] BMP_LIMIT   = 21'h010000;
  localparam logic [20:0] CP_LIMIT    = 21'h110000;
  localparam logic [15:0] HI_SURR     = 16'hD800;
  localparam logic [15:0] LO_SURR     = 16'hDC00;
  localparam logic [15:0] CAP_RESET   = 16'hFFFF;
  localparam int          MAX_RESULTS = 3;

  // One result item as seen on the output channel
  typedef struct packed {
    logic [15:0] unit_value;
    logic        is_summary;
    status_t     status;
    logic [15:0] unit_count;
    logic        bom_seen;
    logic        run_last;
  } item_t;

  // All results caused by one byte, oldest at index 0
  typedef struct packed {
    item_t [MAX_RESULTS-1:0] items;
    logic  [1:0]             n;
  } bundle_t;

endpackage

// ===== hw/rtl/u8u16_if.sv =====
`timescale 1ns / 1ps

// Byte input channel
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, in_byte, end_of_string, input ready);
  modport sink   (input valid, in_byte, end_of_string, output ready);
endinterface

// UTF-16 unit / summary result channel
interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] unit_value;
  logic        is_summary;
  logic [2:0]  status;
  logic [15:0] unit_count;
  logic        bom_seen;
  logic        run_last;

  modport source (output valid, unit_value, is_summary, status, unit_count, bom_seen,
                  run_last, input ready);
  modport sink   (input valid, unit_value, is_summary, status, unit_count, bom_seen,
                  run_last, output ready);
endinterface

// ===== hw/rtl/u8u16_step.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Per-string decode state plus the logic that turns one byte into its results.
module u8u16_step #(
  parameter int COUNT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                end_of_string,
  input  logic [15:0]         cap,
  output u8u16_pkg::bundle_t  bundle
);

  // Width that holds both the count and the 16-bit capacity, plus one
  localparam int UW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

  logic [20:0]               acc_r, acc_nxt;
  logic [1:0]                pend_r, pend_nxt;
  logic [1:0]                pos_r, pos_nxt;
  u8u16_pkg::status_t        err_r, err_nxt;
  logic [COUNT_BITS-1:0]     units_r, units_nxt;
  logic                      bom_r, bom_nxt;

  logic                      done;
  logic [20:0]               cp;
  logic [19:0]               cp_off;
  logic [UW-1:0]             cap_ext, cap_max, cap_f, units_ext;
  logic [1:0]                nu;
  logic [15:0]               u0_val, u1_val;
  logic [UW-1:0]             cnt0_ext, cnt1_ext, cntf_ext;
  u8u16_pkg::item_t          u0, u1, sm;

  assign cap_max = UW'((UW'(1) << COUNT_BITS) - UW'(1));
  assign cap_ext = UW'(cap);
  assign cap_f   = (cap_ext < cap_max) ? cap_ext : cap_max;

  // Byte classification, accumulation and unit generation
  always_comb begin
    acc_nxt   = acc_r;
    pend_nxt  = pend_r;
    err_nxt   = err_r;
    units_nxt = units_r;
    bom_nxt   = bom_r;
    done      = 1'b0;
    nu        = 2'd0;
    u0_val    = '0;
    u1_val    = '0;
    cnt0_ext  = '0;
    cnt1_ext  = '0;
    cp        = '0;
    cp_off    = '0;
    units_ext = '0;

    if (err_r == u8u16_pkg::ST_OK) begin
      if (pend_r == 2'd0) begin
        if (in_byte < 8'h80) begin
          acc_nxt = 21'(in_byte);
          done    = 1'b1;
        end else if (in_byte < 8'hC0) begin
          err_nxt = u8u16_pkg::ST_BAD_LEAD;
        end else if (in_byte < 8'hE0) begin
          acc_nxt  = 21'(in_byte[4:0]);
          pend_nxt = 2'd1;
        end else if (in_byte < 8'hF0) begin
          acc_nxt  = 21'(in_byte[3:0]);
          pend_nxt = 2'd2;
        end else if (in_byte < 8'hF8) begin
          acc_nxt  = 21'(in_byte[2:0]);
          pend_nxt = 2'd3;
        end else begin
          err_nxt = u8u16_pkg::ST_BAD_LEAD;
        end
      end else if (in_byte[7:6] != 2'b10) begin
        err_nxt = u8u16_pkg::ST_BAD_CONT;
      end else begin
        acc_nxt  = {acc_r[14:0], in_byte[5:0]};
        pend_nxt = pend_r - 2'd1;
        done     = (pend_r == 2'd1);
      end

      if (done) begin
        cp        = acc_nxt;
        cp_off    = 20'(cp - u8u16_pkg::BMP_LIMIT);
        units_ext = UW'(units_r);
        if (cp == u8u16_pkg::BOM_CP && pos_r == 2'd2) begin
          bom_nxt = 1'b1;
        end else if (cp < u8u16_pkg::BMP_LIMIT) begin
          if (units_ext >= cap_f) begin
            err_nxt = u8u16_pkg::ST_FULL;
          end else begin
            units_nxt = units_r + COUNT_BITS'(1);
            nu        = 2'd1;
            u0_val    = cp[15:0];
            cnt0_ext  = units_ext + UW'(1);
          end
        end else if (cp < u8u16_pkg::CP_LIMIT) begin
          if (units_ext + UW'(1) >= cap_f) begin
            err_nxt = u8u16_pkg::ST_FULL;
          end else begin
            units_nxt = units_r + COUNT_BITS'(2);
            nu        = 2'd2;
            u0_val    = u8u16_pkg::HI_SURR | 16'(cp_off[19:10]);
            u1_val    = u8u16_pkg::LO_SURR | 16'(cp_off[9:0]);
            cnt0_ext  = units_ext + UW'(1);
            cnt1_ext  = units_ext + UW'(2);
          end
        end else begin
          err_nxt = u8u16_pkg::ST_RANGE;
        end
        acc_nxt = '0;
      end

      if (end_of_string && err_nxt == u8u16_pkg::ST_OK && pend_nxt != 2'd0) begin
        err_nxt = u8u16_pkg::ST_TRUNC;
      end
    end

    pos_nxt = (pos_r < 2'd3) ? pos_r + 2'd1 : pos_r;
  end

  // Pack unit items and the summary into the result bundle
  always_comb begin
    cntf_ext = UW'(units_nxt);

    u0            = '0;
    u0.unit_value = u0_val;
    u0.status     = u8u16_pkg::ST_OK;
    u0.unit_count = cnt0_ext[15:0];
    u0.bom_seen   = bom_nxt;

    u1            = '0;
    u1.unit_value = u1_val;
    u1.status     = u8u16_pkg::ST_OK;
    u1.unit_count = cnt1_ext[15:0];
    u1.bom_seen   = bom_nxt;

    sm            = '0;
    sm.is_summary = 1'b1;
    sm.status     = err_nxt;
    sm.unit_count = cntf_ext[15:0];
    sm.bom_seen   = bom_nxt;

    bundle = '0;
    if (nu != 2'd0) begin
      bundle.items[0] = u0;
    end
    if (nu == 2'd2) begin
      bundle.items[1] = u1;
    end
    if (end_of_string) begin
      bundle.items[nu] = sm;
    end
    bundle.n = nu + 2'(end_of_string);
    if (bundle.n != 2'd0) begin
      bundle.items[bundle.n - 2'd1].run_last = 1'b1;
    end
  end

  // String state; the summary byte clears it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      pend_r  <= '0;
      pos_r   <= '0;
      err_r   <= u8u16_pkg::ST_OK;
      units_r <= '0;
      bom_r   <= 1'b0;
    end else if (accept) begin
      if (end_of_string) begin
        acc_r   <= '0;
        pend_r  <= '0;
        pos_r   <= '0;
        err_r   <= u8u16_pkg::ST_OK;
        units_r <= '0;
        bom_r   <= 1'b0;
      end else begin
        acc_r   <= acc_nxt;
        pend_r  <= pend_nxt;
        pos_r   <= pos_nxt;
        err_r   <= err_nxt;
        units_r <= units_nxt;
        bom_r   <= bom_nxt;
      end
    end
  end

  // Once a string has failed, no more units come out of it
  `U8_ASSERT(a_err_no_units, accept && err_r != u8u16_pkg::ST_OK |-> nu == 2'd0, "unit after error")
  // An accepted last byte leaves the string state cleared
  `U8_ASSERT(a_eos_clears, accept && end_of_string |=> units_r == '0 && pend_r == 2'd0 && !bom_r, "string state not cleared")

endmodule

// ===== hw/rtl/utf8_to_utf16_decoder_top.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// The first result of a byte is offered in the cycle after its transfer.
// Throughput: one byte per cycle while each byte yields at most one result and the
// receiver is ready; a byte yielding more (up to 3) holds the input until its last item
// leaves the result buffer, one item per ready cycle. Reset is synchronous, active low:
// string state and the result buffer clear, and the capacity cap_r returns to 65535.

module utf8_to_utf16_decoder_top #(
  parameter int COUNT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  u8u16_in_if.sink            in_ch,
  u8u16_out_if.source         out_ch,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);

  logic [15:0]                                cap_r;
  u8u16_pkg::bundle_t                         bundle;
  u8u16_pkg::item_t [u8u16_pkg::MAX_RESULTS-1:0] items_r;
  logic [1:0]                                 cnt_r;
  logic                                       in_xfer, out_xfer;

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= u8u16_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // Take a byte when the buffer is empty or its last item leaves this cycle
  assign out_xfer    = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ch.ready);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  u8u16_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_xfer),
    .in_byte       (in_ch.in_byte),
    .end_of_string (in_ch.end_of_string),
    .cap           (cap_r),
    .bundle        (bundle)
  );

  // Result buffer: item count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_xfer) begin
      cnt_r <= bundle.n;
    end else if (out_xfer) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // Result buffer: payload, shifted toward the head on each transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      items_r <= bundle.items;
    end else if (out_xfer) begin
      items_r[0] <= items_r[1];
      items_r[1] <= items_r[2];
    end
  end

  assign out_ch.valid      = (cnt_r != 2'd0);
  assign out_ch.unit_value = items_r[0].unit_value;
  assign out_ch.is_summary = items_r[0].is_summary;
  assign out_ch.status     = items_r[0].status;
  assign out_ch.unit_count = items_r[0].unit_count;
  assign out_ch.bom_seen   = items_r[0].bom_seen;
  assign out_ch.run_last   = items_r[0].run_last;

  // The head carries run_last exactly when it is the last buffered item
  `U8_ASSERT(a_run_last_pos, out_ch.valid |-> out_ch.run_last == (cnt_r == 2'd1), "run_last misplaced")
  // A last byte always leaves a summary pending
  `U8_ASSERT(a_eos_summary, in_xfer && in_ch.end_of_string |=> cnt_r != 2'd0, "summary lost")
  // Reset leaves the result buffer empty
  `U8_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> cnt_r == 2'd0, "buffer not empty after reset")

endmodule

// ===== bench/u8u16_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels, predicts the UTF-16 items of each byte transfer and
// compares every result transfer against the oldest prediction.
module u8u16_checker #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  u8u16_in_if         in_mon,
  u8u16_out_if        out_mon,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output int          exp_pending,
  output int          fail_count
);

  // Largest unit count the block's counter can hold
  localparam int CNT_MAX = (COUNT_BITS >= 31) ? 32'h7FFF_FFFF : (1 << COUNT_BITS) - 1;

  // Predictor state, one string at a time
  logic [15:0]         cap_reg;
  logic [20:0]         cp_acc;
  logic [1:0]          cont_left;
  logic [1:0]          byte_pos;
  u8u16_pkg::status_t  str_err;
  int                  unit_total;
  logic                bom_hit;

  u8u16_pkg::item_t utf16_q[$];
  int               mism = 0;

  function automatic int cap_eff();
    return (int'(cap_reg) < CNT_MAX) ? int'(cap_reg) : CNT_MAX;
  endfunction

  function automatic u8u16_pkg::item_t make_item(logic [15:0] v, logic summ,
                                                 u8u16_pkg::status_t st);
    u8u16_pkg::item_t it;
    it.unit_value = v;
    it.is_summary = summ;
    it.status     = st;
    it.unit_count = 16'(unit_total);
    it.bom_seen   = bom_hit;
    it.run_last   = 1'b0;
    return it;
  endfunction

  task automatic clear_string();
    cp_acc     = '0;
    cont_left  = '0;
    byte_pos   = '0;
    str_err    = u8u16_pkg::ST_OK;
    unit_total = 0;
    bom_hit    = 1'b0;
  endtask

  // Expected items for one accepted byte
  task automatic transcode_byte(input logic [7:0] b, input logic eos);
    u8u16_pkg::item_t burst[$];
    logic [1:0]       pos;
    logic [20:0]      d;
    bit               done;
    pos  = byte_pos;
    done = 1'b0;
    if (str_err == u8u16_pkg::ST_OK) begin
      if (cont_left == 2'd0) begin
        if (b < 8'h80) begin
          cp_acc = {13'h0, b};
          done   = 1'b1;
        end else if (b < 8'hC0) begin
          str_err = u8u16_pkg::ST_BAD_LEAD;
        end else if (b < 8'hE0) begin
          cp_acc    = {16'h0, b[4:0]};
          cont_left = 2'd1;
        end else if (b < 8'hF0) begin
          cp_acc    = {17'h0, b[3:0]};
          cont_left = 2'd2;
        end else if (b < 8'hF8) begin
          cp_acc    = {18'h0, b[2:0]};
          cont_left = 2'd3;
        end else begin
          str_err = u8u16_pkg::ST_BAD_LEAD;
        end
      end else if (b[7:6] != 2'b10) begin
        str_err = u8u16_pkg::ST_BAD_CONT;
      end else begin
        cp_acc    = {cp_acc[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        done      = (cont_left == 2'd0);
      end

      // Finished code point: BOM, single unit, pair, capacity-full or range error
      if (done) begin
        if (cp_acc == u8u16_pkg::BOM_CP && pos == 2'd2) begin
          bom_hit = 1'b1;
        end else if (cp_acc < u8u16_pkg::BMP_LIMIT) begin
          if (unit_total >= cap_eff()) begin
            str_err = u8u16_pkg::ST_FULL;
          end else begin
            unit_total++;
            burst.push_back(make_item(cp_acc[15:0], 1'b0, u8u16_pkg::ST_OK));
          end
        end else if (cp_acc < u8u16_pkg::CP_LIMIT) begin
          if (unit_total + 1 >= cap_eff()) begin
            str_err = u8u16_pkg::ST_FULL;
          end else begin
            d = cp_acc - u8u16_pkg::BMP_LIMIT;
            unit_total++;
            burst.push_back(make_item(u8u16_pkg::HI_SURR | {6'h0, d[19:10]}, 1'b0,
                                      u8u16_pkg::ST_OK));
            unit_total++;
            burst.push_back(make_item(u8u16_pkg::LO_SURR | {6'h0, d[9:0]}, 1'b0,
                                      u8u16_pkg::ST_OK));
          end
        end else begin
          str_err = u8u16_pkg::ST_RANGE;
        end
        cp_acc = '0;
      end

      if (eos && str_err == u8u16_pkg::ST_OK && cont_left != 2'd0) begin
        str_err = u8u16_pkg::ST_TRUNC;
      end
    end

    if (byte_pos < 2'd3) byte_pos = byte_pos + 2'd1;

    if (eos) begin
      burst.push_back(make_item(16'h0, 1'b1, str_err));
      clear_string();
    end

    if (burst.size() > 0) burst[burst.size()-1].run_last = 1'b1;
    foreach (burst[i]) utf16_q.push_back(burst[i]);
  endtask

  task automatic cmp_field(input string name, input logic [15:0] e, input logic [15:0] a);
    if (a !== e) begin
      mism++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
    end
  endtask

  task automatic check_result();
    u8u16_pkg::item_t want;
    if (utf16_q.size() == 0) begin
      mism++;
      $display("%0t: unexpected result, expected none, actual unit %0h summary %0b status %0d",
               $time, out_mon.unit_value, out_mon.is_summary, out_mon.status);
    end else begin
      want = utf16_q.pop_front();
      cmp_field("unit_value", want.unit_value, out_mon.unit_value);
      cmp_field("is_summary", 16'(want.is_summary), 16'(out_mon.is_summary));
      cmp_field("status", 16'(want.status), 16'(out_mon.status));
      cmp_field("unit_count", want.unit_count, out_mon.unit_count);
      cmp_field("bom_seen", 16'(want.bom_seen), 16'(out_mon.bom_seen));
      cmp_field("run_last", 16'(want.run_last), 16'(out_mon.run_last));
    end
  endtask

  // Results first, then a register write, then the new byte
  always @(posedge clk) begin
    if (!rst_n) begin
      cap_reg = u8u16_pkg::CAP_RESET;
      clear_string();
      utf16_q.delete();
      exp_pending <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) check_result();
      if (cfg_we) cap_reg = cfg_wdata;
      if (in_mon.valid && in_mon.ready) transcode_byte(in_mon.in_byte, in_mon.end_of_string);
      exp_pending <= utf16_q.size();
    end
    fail_count <= mism;
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        tx_eos;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        rx_ready = 1'b0;

  int rx_mode    = 0;
  int rx_left    = 0;
  int burst_left = 0;
  int exp_pending;
  int fail_count;

  u8u16_in_if  in_ch();
  u8u16_out_if out_ch();

  assign in_ch.valid         = tx_valid;
  assign in_ch.in_byte       = tx_byte;
  assign in_ch.end_of_string = tx_eos;
  assign out_ch.ready        = rx_ready;

  utf8_to_utf16_decoder_top #(.COUNT_BITS(16)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  u8u16_checker #(.COUNT_BITS(16)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .exp_pending (exp_pending),
    .fail_count  (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls: modes of random length, from always ready to mostly stalled
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(20, 80);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: rx_ready <= 1'b1;
      1: rx_ready <= 1'($urandom_range(0, 1));
      2: rx_ready <= ($urandom_range(0, 3) == 0);
      default: rx_ready <= rx_left[2];
    endcase
  end

  // One byte transfer; bursts of random length separated by random gaps
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        tx_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    tx_valid <= 1'b1;
    tx_byte  <= b;
    tx_eos   <= eos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_string(input logic [7:0] s[$]);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  // Hold the input until every predicted item has come, then let the pipe settle
  task automatic drain_idle();
    tx_valid <= 1'b0;
    @(posedge clk);
    while (exp_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [15:0] v);
    drain_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic append_utf8(ref logic [7:0] s[$], input logic [20:0] cp, input int len);
    case (len)
      1: s.push_back({1'b0, cp[6:0]});
      2: begin
        s.push_back({3'b110, cp[10:6]});
        s.push_back({2'b10, cp[5:0]});
      end
      3: begin
        s.push_back({4'b1110, cp[15:12]});
        s.push_back({2'b10, cp[11:6]});
        s.push_back({2'b10, cp[5:0]});
      end
      default: begin
        s.push_back({5'b11110, cp[20:18]});
        s.push_back({2'b10, cp[17:12]});
        s.push_back({2'b10, cp[11:6]});
        s.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Mostly well-formed strings, some noise, truncation and corrupted bytes
  task automatic make_string(ref logic [7:0] s[$]);
    int nchar;
    int idx;
    logic [20:0] cp;
    s.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 5) == 0) begin
        s.push_back(8'hEF);
        s.push_back(8'hBB);
        s.push_back(8'hBF);
      end
      nchar = $urandom_range(1, 5);
      repeat (nchar) begin
        case ($urandom_range(0, 9))
          0, 1, 2: append_utf8(s, 21'($urandom_range(0, 'h7F)), 1);
          3, 4:    append_utf8(s, 21'($urandom_range(0, 'h7FF)), 2);
          5:       append_utf8(s, 21'($urandom_range(0, 'hFFFF)), 3);
          6: begin
            cp = ($urandom_range(0, 2) == 0) ? u8u16_pkg::BOM_CP
                                             : 21'($urandom_range(0, 'hFFFF));
            append_utf8(s, cp, 3);
          end
          7, 8:    append_utf8(s, 21'($urandom_range('h10000, 'h10FFFF)), 4);
          default: append_utf8(s, 21'($urandom_range('h110000, 'h1FFFFF)), 4);
        endcase
      end
      if (s.size() > 1 && $urandom_range(0, 7) == 0) void'(s.pop_back());
      if ($urandom_range(0, 7) == 0) begin
        idx = $urandom_range(0, s.size() - 1);
        s[idx] = 8'($urandom_range(0, 255));
      end
    end
  endtask

  initial begin
    logic [7:0]  str[$];
    logic [15:0] caps[6];
    int          phase_sent;

    rst_n     <= 1'b0;
    tx_valid  <= 1'b0;
    tx_byte   <= 8'h00;
    tx_eos    <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= 16'h0000;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: BOM and ASCII extremes, longest forms, each error kind
    set_capacity(u8u16_pkg::CAP_RESET);
    send_string('{8'hEF, 8'hBB, 8'hBF, 8'h00, 8'h7F});
    send_string('{8'hDF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF});
    send_string('{8'h80});
    send_string('{8'hF8, 8'h41});
    send_string('{8'hC2, 8'h41});
    send_string('{8'hE2, 8'h82});
    send_string('{8'hF4, 8'h90, 8'h80, 8'h80});
    // Capacity lowered mid-string: the pair no longer fits, so neither half is emitted
    send_byte(8'h41, 1'b0);
    set_capacity(16'd2);
    send_string('{8'hF0, 8'h90, 8'h80, 8'h80});

    // Random phases over several capacities, extremes included
    caps = '{16'd0, 16'd3, 16'd1, 16'hFFFF, 16'($urandom_range(2, 9)), 16'hFFFF};
    foreach (caps[p]) begin
      set_capacity(caps[p]);
      phase_sent = 0;
      while (phase_sent < 44) begin
        make_string(str);
        send_string(str);
        phase_sent += str.size();
      end
    end

    drain_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && exp_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/u8u16_pkg.sv
hw/rtl/u8u16_if.sv
hw/rtl/u8u16_step.sv
hw/rtl/utf8_to_utf16_decoder_top.sv
bench/u8u16_checker.sv
bench/tb_top.sv
